>>> src/slh_pkg.sv
// Shared types, constants and helper functions for the long-message hash block.
`timescale 1ns / 1ps
package slh_pkg;

	localparam int NWORDS      = 12;
	localparam int LAST_POS    = NWORDS - 1;
	localparam int BLOCK_BYTES = 8 * NWORDS;
	localparam int END_ROUNDS  = 3;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [63:0] HASH_CONST = 64'hdeadbeefdeadbeef;

	// Register indexes on the configuration port
	localparam logic REG_SEED_FIRST  = 1'b0;
	localparam logic REG_SEED_SECOND = 1'b1;

	// What the back end must do with a queued word
	typedef enum logic [2:0] {
		K_WORD,       // store only
		K_BLOCK,      // store, then mix the full block
		K_LAST_BLOCK, // store, mix, then deliver the hash
		K_TAIL,       // store, pad, fold and run end rounds, deliver
		K_EMPTY       // nothing left to add, deliver the hash
	} kind_t;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  pos;
		logic [6:0]  rem;
		kind_t       kind;
	} q_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_FOLD,
		ST_END,
		ST_DONE
	} state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
		logic [127:0] t;
		t = {x, x} << r;
		return t[127:64];
	endfunction

	// Rotation per mix row
	function automatic logic [5:0] mix_rot(input logic [3:0] row);
		logic [5:0] r;
		case (row)
			4'd0:    r = 6'd11;
			4'd1:    r = 6'd32;
			4'd2:    r = 6'd43;
			4'd3:    r = 6'd31;
			4'd4:    r = 6'd17;
			4'd5:    r = 6'd28;
			4'd6:    r = 6'd39;
			4'd7:    r = 6'd57;
			4'd8:    r = 6'd55;
			4'd9:    r = 6'd54;
			4'd10:   r = 6'd22;
			4'd11:   r = 6'd46;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// Rotation per end-round row
	function automatic logic [5:0] end_rot(input logic [3:0] row);
		logic [5:0] r;
		case (row)
			4'd0:    r = 6'd44;
			4'd1:    r = 6'd15;
			4'd2:    r = 6'd34;
			4'd3:    r = 6'd21;
			4'd4:    r = 6'd38;
			4'd5:    r = 6'd33;
			4'd6:    r = 6'd10;
			4'd7:    r = 6'd13;
			4'd8:    r = 6'd38;
			4'd9:    r = 6'd53;
			4'd10:   r = 6'd42;
			4'd11:   r = 6'd54;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// Keep the low cnt bytes of a word
	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = (4'(b) < cnt) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

endpackage

>>> src/slh_front.sv
// Front end: accepts message words, masks them and tags what each one triggers.
`timescale 1ns / 1ps
module slh_front import slh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // [63:0] data_word, [67:64] byte_count, [71:68] zero
	input  logic        s_axis_tlast,  // last_word
	output logic        push_valid,
	input  logic        push_ready,
	output q_entry_t    push_entry
);

	logic [3:0] pos_q;
	logic [3:0] cnt;
	logic [6:0] rem;
	logic       accept;

	assign s_axis_tready = push_ready;
	assign push_valid    = s_axis_tvalid;
	assign accept        = s_axis_tvalid && push_ready;

	// Byte count only matters on the last word and saturates at eight
	always_comb begin
		cnt = 4'd8;
		if (s_axis_tlast && s_axis_tdata[67:64] <= 4'd8) begin
			cnt = s_axis_tdata[67:64];
		end
		rem = {pos_q, 3'b000} + 7'(cnt);
	end

	// Classify the word
	always_comb begin
		push_entry.data = s_axis_tdata[63:0] & byte_mask(cnt);
		push_entry.pos  = pos_q;
		push_entry.rem  = rem;
		if (!s_axis_tlast) begin
			push_entry.kind = (pos_q == 4'(LAST_POS)) ? K_BLOCK : K_WORD;
		end else if (rem == 7'(BLOCK_BYTES)) begin
			push_entry.kind = K_LAST_BLOCK;
		end else if (rem == 7'd0) begin
			push_entry.kind = K_EMPTY;
		end else begin
			push_entry.kind = K_TAIL;
		end
	end

	// Word position inside the current block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
		end else if (cfg_we) begin
			pos_q <= 4'd0;
		end else if (accept) begin
			if (s_axis_tlast || pos_q == 4'(LAST_POS)) begin
				pos_q <= 4'd0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

endmodule

>>> src/slh_queue.sv
// Short queue between the front end and the mixing back end.
`timescale 1ns / 1ps
module slh_queue import slh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_entry,
	output logic     pop_valid,
	input  logic     pop,
	output q_entry_t pop_entry
);

	q_entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/slh_back.sv
// Back end: block buffer, twelve-word mix state, mix and end-round sequencer, result register.
`timescale 1ns / 1ps
module slh_back import slh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         q_valid,
	input  q_entry_t     q_entry,
	output logic         q_pop,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata   // [63:0] hash_first, [127:64] hash_second,
	                                    // [159:128] hash_low32
);

	state_t      state_q, state_d;
	logic [3:0]  row_q;
	logic        phase_q;
	logic [1:0]  round_q;
	logic        fin_q;
	logic [3:0]  pos_q;
	logic [6:0]  rem_q;
	logic [63:0] seed_a_q, seed_b_q, seed_a_d, seed_b_d;
	logic [63:0] st_q  [NWORDS];
	logic [63:0] st_d  [NWORDS];
	logic [63:0] upd   [NWORDS];
	logic [63:0] pad   [NWORDS];
	logic [63:0] buf_q [NWORDS];
	logic [63:0] sum;
	logic        out_valid_q;
	logic [63:0] out_first_q, out_second_q;
	logic        out_load;
	logic        mix_last;
	logic        end_last;

	assign mix_last = (row_q == 4'(LAST_POS)) && phase_q;
	assign end_last = (row_q == 4'(LAST_POS)) && (round_q == 2'(END_ROUNDS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_entry.kind)
						K_BLOCK, K_LAST_BLOCK: state_d = ST_MIX;
						K_TAIL:                state_d = ST_FOLD;
						K_EMPTY:               state_d = ST_DONE;
						default:               state_d = ST_IDLE;
					endcase
				end
			end
			ST_MIX:  if (mix_last) state_d = fin_q ? ST_DONE : ST_IDLE;
			ST_FOLD: state_d = ST_END;
			ST_END:  if (end_last) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs; while mixing, words of the next block fill slots already consumed
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_MIX:  q_pop = q_valid && q_entry.kind == K_WORD && q_entry.pos < row_q;
			ST_DONE: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	// Seed registers as they stand after this cycle
	always_comb begin
		seed_a_d = seed_a_q;
		seed_b_d = seed_b_q;
		if (cfg_we && cfg_index == REG_SEED_FIRST) seed_a_d = cfg_data;
		if (cfg_we && cfg_index == REG_SEED_SECOND) seed_b_d = cfg_data;
	end

	// Zero-padded final block with the remainder count in its top byte
	always_comb begin
		for (int k = 0; k < NWORDS; k++) begin
			pad[k] = (4'(k) <= pos_q) ? buf_q[k] : 64'd0;
		end
		pad[LAST_POS][63:56] = {1'b0, rem_q};
	end

	// Mix state update; the state rotates by one word per row so each row works on fixed slots
	always_comb begin
		sum = st_q[0] + buf_q[row_q];
		upd = st_q;
		st_d = st_q;
		case (state_q)
			ST_MIX: begin
				if (!phase_q) begin
					st_d[0]        = sum;
					st_d[2]        = st_q[2] ^ st_q[10];
					st_d[LAST_POS] = st_q[LAST_POS] ^ sum;
				end else begin
					upd[0]        = rotl64(st_q[0], mix_rot(row_q));
					upd[LAST_POS] = st_q[LAST_POS] + st_q[1];
					for (int k = 0; k < NWORDS; k++) begin
						st_d[k] = upd[(k + 1) % NWORDS];
					end
				end
			end
			ST_FOLD: begin
				for (int k = 0; k < NWORDS; k++) begin
					st_d[k] = st_q[k] + pad[k];
				end
			end
			ST_END: begin
				upd[LAST_POS] = st_q[LAST_POS] + st_q[1];
				upd[2]        = st_q[2] ^ upd[LAST_POS];
				upd[1]        = rotl64(st_q[1], end_rot(row_q));
				for (int k = 0; k < NWORDS; k++) begin
					st_d[k] = upd[(k + 1) % NWORDS];
				end
			end
			default: ;
		endcase
		// Rearm after a result or a seed write
		if (out_load || cfg_we) begin
			for (int k = 0; k < NWORDS; k++) begin
				case (k % 3)
					0:       st_d[k] = seed_a_d;
					1:       st_d[k] = seed_b_d;
					default: st_d[k] = HASH_CONST;
				endcase
			end
		end
	end

	// Block buffer
	always_ff @(posedge clk) begin
		if (q_pop && q_entry.kind != K_EMPTY) begin
			buf_q[q_entry.pos] <= q_entry.data;
		end
	end

	// Mix state and seeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= 64'd0;
			seed_b_q <= 64'd0;
			for (int k = 0; k < NWORDS; k++) begin
				st_q[k] <= (k % 3 == 2) ? HASH_CONST : 64'd0;
			end
		end else begin
			seed_a_q <= seed_a_d;
			seed_b_q <= seed_b_d;
			st_q     <= st_d;
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= 4'd0;
			phase_q <= 1'b0;
			round_q <= 2'd0;
			fin_q   <= 1'b0;
			pos_q   <= 4'd0;
			rem_q   <= 7'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					row_q   <= 4'd0;
					phase_q <= 1'b0;
					round_q <= 2'd0;
					if (q_pop) begin
						fin_q <= q_entry.kind == K_LAST_BLOCK;
						pos_q <= q_entry.pos;
						rem_q <= q_entry.rem;
					end
				end
				ST_MIX: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						row_q <= mix_last ? 4'd0 : row_q + 4'd1;
					end
				end
				ST_END: begin
					if (row_q == 4'(LAST_POS)) begin
						row_q   <= 4'd0;
						round_q <= end_last ? 2'd0 : round_q + 2'd1;
					end else begin
						row_q <= row_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_first_q  <= st_q[0];
			out_second_q <= st_q[1];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_second_q[31:0], out_second_q, out_first_q};

endmodule

>>> src/spooky_long_hash_128.sv
// Top level of the streaming 128-bit long-message hash.
`timescale 1ns / 1ps
// Streams a message in as little-endian 64-bit words (byte_count honored on the
// tlast word only) and returns one item per message with both 64-bit hash halves
// and the 32-bit hash. The front end tags each word and feeds a two-item queue;
// the back end stores a word that does not close a block into its buffer and
// mixes each full 96-byte block in twelve mix rows of two phases each. While a
// block mixes, the first words of the next block go into buffer slots whose row
// is done, so words of a long message are still taken while a block mixes. A
// final partial block takes a fold step and three end rounds of twelve rows; the
// hash then sits in an output register, so the next message is taken while the
// result waits. Seed writes (index 0 first seed, index 1 second seed) rearm the
// state and drop any message in progress; write them only while the block is idle.
module spooky_long_hash_128 import slh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [71:0]  s_axis_tdata,  // [63:0] data_word, [67:64] byte_count, [71:68] zero
	input  logic         s_axis_tlast,  // last_word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata   // [63:0] hash_first, [127:64] hash_second,
	                                    // [159:128] hash_low32
);

	logic     push_valid, push_ready;
	q_entry_t push_entry;
	logic     q_valid, q_pop;
	q_entry_t q_entry;

	slh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_entry    (push_entry)
	);

	slh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_entry  (q_entry)
	);

	slh_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> tb/spooky_long_hash_128_tb.sv
// Self-checking testbench for the streaming 128-bit long-message hash.
`timescale 1ns / 1ps

// Tracks the hash state word by word and holds the digests still owed by the block
class digest_tracker;
	bit [63:0] seed_a;
	bit [63:0] seed_b;
	bit [63:0] lanes[12];
	bit [63:0] blk[12];
	int unsigned fill;
	bit [159:0] pending[$];
	int unsigned mismatches;
	int unsigned digests_seen;
	int unsigned words_taken;
	int unsigned msgs_taken;
	int unsigned mix_r[12] = '{11, 32, 43, 31, 17, 28, 39, 57, 55, 54, 22, 46};
	int unsigned end_r[12] = '{44, 15, 34, 21, 38, 33, 10, 13, 38, 53, 42, 54};

	function new();
		seed_a = '0;
		seed_b = '0;
		mismatches = 0;
		digests_seen = 0;
		words_taken = 0;
		msgs_taken = 0;
		rearm();
	endfunction

	// Lanes take seed_a, seed_b and the constant in turn
	function void rearm();
		for (int i = 0; i < 12; i++)
			lanes[i] = (i % 3 == 0) ? seed_a : (i % 3 == 1) ? seed_b : slh_pkg::HASH_CONST;
		fill = 0;
	endfunction

	function bit [63:0] rotl(bit [63:0] x, int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function void mix_blk();
		int unsigned a, b, c, d;
		for (int i = 0; i < 12; i++) begin
			a = (i + 2) % 12;
			b = (i + 10) % 12;
			c = (i + 11) % 12;
			d = (i + 1) % 12;
			lanes[i] += blk[i];
			lanes[a] ^= lanes[b];
			lanes[c] ^= lanes[i];
			lanes[i] = rotl(lanes[i], mix_r[i]);
			lanes[c] += lanes[d];
		end
	endfunction

	function void end_round();
		int unsigned a, b, c;
		for (int i = 0; i < 12; i++) begin
			a = (i + 11) % 12;
			b = (i + 1) % 12;
			c = (i + 2) % 12;
			lanes[a] += lanes[b];
			lanes[c] ^= lanes[a];
			lanes[b] = rotl(lanes[b], end_r[i]);
		end
	endfunction

	function void set_seed(logic idx, bit [63:0] v);
		if (idx == slh_pkg::REG_SEED_FIRST)
			seed_a = v;
		else
			seed_b = v;
		rearm();
	endfunction

	// One accepted item; a last word queues the digest it closes
	function void take_word(bit [63:0] data, bit [3:0] cnt, bit last);
		int unsigned n;
		int unsigned rem;
		bit [63:0] w;
		n = (!last || cnt > 8) ? 8 : cnt;
		w = data;
		if (n < 8)
			w = data & ((64'd1 << (8 * n)) - 64'd1);
		words_taken++;
		if (!last) begin
			blk[fill] = w;
			fill++;
			if (fill == 12) begin
				mix_blk();
				fill = 0;
			end
			return;
		end
		msgs_taken++;
		rem = 8 * fill + n;
		if (rem == 96) begin
			blk[fill] = w;
			mix_blk();
		end else if (rem != 0) begin
			// zero pad, length byte on top of the block, then three end rounds
			blk[fill] = w;
			for (int i = fill + 1; i < 12; i++)
				blk[i] = '0;
			blk[11][63:56] = rem[7:0];
			for (int i = 0; i < 12; i++)
				lanes[i] += blk[i];
			repeat (3) end_round();
		end
		pending.push_back({lanes[1][31:0], lanes[1], lanes[0]});
		rearm();
	endfunction

	task report(string what);
		$display("tb: MISMATCH %s", what);
		mismatches++;
	endtask

	task check_digest(logic [159:0] got);
		bit [159:0] want;
		digests_seen++;
		if (pending.size() == 0) begin
			report($sformatf("hash item with none owed: %h", got));
			return;
		end
		want = pending.pop_front();
		if (got[63:0] !== want[63:0])
			report($sformatf("hash_first got %h want %h", got[63:0], want[63:0]));
		if (got[127:64] !== want[127:64])
			report($sformatf("hash_second got %h want %h", got[127:64], want[127:64]));
		if (got[159:128] !== want[159:128])
			report($sformatf("hash_low32 got %h want %h", got[159:128], want[159:128]));
	endtask

	task finish_check();
		if (pending.size() != 0)
			report($sformatf("%0d hash items never delivered", pending.size()));
	endtask
endclass

module spooky_long_hash_128_tb;
	import slh_pkg::*;

	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [63:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;

	digest_tracker trk;
	int idle_tx = 0;
	int idle_rx = 0;
	bit hold_req = 1'b0;
	int unsigned cycles = 0;

	spooky_long_hash_128 u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= idle_rx);
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			trk.check_digest(m_axis_tdata);
	end

	function automatic logic [63:0] rnd64();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < idle_tx) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, cnt, data};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (s_axis_tready !== 1'b1) @(posedge clk);
		trk.take_word(data, cnt, last);
	endtask

	// Non-last words carry random (ignored) byte counts
	task automatic send_message(input int n, input logic [3:0] last_cnt);
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				send_word(rnd64(), last_cnt, 1'b1);
			else
				send_word(rnd64(), 4'($urandom_range(0, 15)), 1'b0);
		end
	endtask

	// Stop offering, wait for every owed digest, then let the back end drain
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (trk.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic idx, input logic [63:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		trk.set_seed(idx, v);
	endtask

	task automatic run_phase(input int tx, input int rx, input int words, input int msgs);
		int unsigned w0, m0, kind, n;
		logic [3:0] lc;
		idle_tx = tx;
		idle_rx = rx;
		w0 = trk.words_taken;
		m0 = trk.msgs_taken;
		while (trk.words_taken - w0 < words || trk.msgs_taken - m0 < msgs) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					n  = 12 * $urandom_range(1, 2);
					lc = 4'd8;
				end
				1: begin
					n  = 1;
					lc = 4'($urandom_range(0, 15));
				end
				2: begin
					n  = $urandom_range(13, 30);
					lc = 4'($urandom_range(0, 15));
				end
				default: begin
					n  = $urandom_range(1, 12);
					lc = ($urandom_range(0, 2) != 0) ? 4'($urandom_range(1, 8))
						: 4'($urandom_range(0, 15));
				end
			endcase
			send_message(n, lc);
		end
		settle();
	endtask

	initial begin
		logic [31:0] s32;
		trk = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_SEED_FIRST;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Directed: seed extremes, empty message, count saturation and masking
		idle_tx = 20;
		idle_rx = 81;
		write_seed(REG_SEED_FIRST, '1);
		write_seed(REG_SEED_SECOND, '0);
		send_word('1, 4'd0, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word(64'h0123456789abcdef, 4'd15, 1'b1);
		send_word('1, 4'd3, 1'b1);
		// count on a non-last word is ignored; a zero-count last word adds nothing
		send_word('0, 4'd2, 1'b0);
		send_word('1, 4'd0, 1'b1);
		// exactly one 96-byte block: mix only, no end rounds
		for (int i = 0; i < 12; i++)
			send_word(rnd64(), (i == 11) ? 4'd8 : 4'd5, i == 11);
		settle();

		// Seed write drops a partial message
		for (int i = 0; i < 3; i++)
			send_word(rnd64(), 4'd8, 1'b0);
		settle();
		write_seed(REG_SEED_SECOND, {$urandom, $urandom});
		send_word(rnd64(), 4'd5, 1'b1);
		settle();

		// Random seeds, sender idles lightly, receiver heavily
		write_seed(REG_SEED_FIRST, {$urandom, $urandom});
		write_seed(REG_SEED_SECOND, {$urandom, $urandom});
		run_phase(20, 81, 140, 15);

		// 32-bit seeding, the other way round
		s32 = $urandom;
		write_seed(REG_SEED_FIRST, {32'h0, s32});
		write_seed(REG_SEED_SECOND, {32'h0, s32});
		run_phase(81, 20, 140, 15);

		// All-ones seeds, no idling, long receiver hold-off at the start
		write_seed(REG_SEED_FIRST, '1);
		write_seed(REG_SEED_SECOND, '1);
		hold_req = 1'b1;
		run_phase(0, 0, 140, 15);

		trk.finish_check();
		$display("tb: %0d words in %0d messages sent, %0d hash items checked, %0d mismatches",
			trk.words_taken, trk.msgs_taken, trk.digests_seen, trk.mismatches);
		$display("tb: covered empty, exact-block and padded messages, count saturation, %s",
			"seed reload mid-message, 32-bit seeding and output back-pressure");
		if (trk.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
